@@ hdl/lrgd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrgd_pkg
// Shared types, constants and saturation helpers of the regression trainer.
// ----------------------------------------------------------------------------
package lrgd_pkg;

  localparam int NF       = 4;
  localparam int DW       = 32;
  localparam int FRAC     = 16;
  localparam int LR_W     = 24;
  localparam int ITER_W   = 20;
  localparam int ACC_W    = 64;
  localparam int MEAN_W   = 40;
  localparam int IDX_W    = $clog2(NF + 1);
  localparam int XI_W     = (NF > 1) ? $clog2(NF) : 1;
  localparam int ROW_W    = NF * DW;

  // input function codes
  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_PREDICT = 1'b1;

  // result kind codes
  localparam logic KIND_WEIGHT  = 1'b0;
  localparam logic KIND_PRED    = 1'b1;

  // configuration register indexes
  localparam logic REG_LEARNING_RATE   = 1'b0;
  localparam logic REG_ITERATION_COUNT = 1'b1;

  localparam logic signed [ACC_W-1:0] DW_MAX   = 64'sd2147483647;
  localparam logic signed [ACC_W-1:0] DW_MIN   = -64'sd2147483648;
  localparam logic signed [ACC_W-1:0] MEAN_MAX = 64'sd549755813887;
  localparam logic signed [ACC_W-1:0] MEAN_MIN = -64'sd549755813888;

  typedef logic signed [DW-1:0]    data_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [ROW_W-1:0]        row_t;

  // clamp a wide value to the data word range
  function automatic data_t sat_dw(input acc_t v);
    data_t r;
    if (v > DW_MAX) begin
      r = DW_MAX[DW-1:0];
    end else if (v < DW_MIN) begin
      r = DW_MIN[DW-1:0];
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  // clamp a quotient to the mean range
  function automatic logic signed [MEAN_W-1:0] sat_mean(input acc_t v);
    logic signed [MEAN_W-1:0] r;
    if (v > MEAN_MAX) begin
      r = MEAN_MAX[MEAN_W-1:0];
    end else if (v < MEAN_MIN) begin
      r = MEAN_MIN[MEAN_W-1:0];
    end else begin
      r = v[MEAN_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/lrgd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrgd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lrgd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/lrgd_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrgd_div
// Iterative signed divide of a 64-bit sum by an unsigned sample count,
// one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module lrgd_div #(
  parameter int CW = 9
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  lrgd_pkg::acc_t dividend,
  input  logic [CW-1:0]  divisor,
  output logic        done,
  output lrgd_pkg::acc_t quotient
);
  import lrgd_pkg::*;

  logic [ACC_W-1:0]        q_r, q_nxt;
  logic [CW-1:0]           rem_r, rem_nxt;
  logic [$clog2(ACC_W)-1:0] cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic                    neg_r, neg_nxt;
  logic [CW:0]             rem_sh;

  // restoring division step
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r, q_r[ACC_W-1]};
    if (start) begin
      neg_nxt  = dividend[ACC_W-1];
      q_nxt    = dividend[ACC_W-1] ? ACC_W'(-dividend) : dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, divisor}) begin
        rem_nxt = CW'(rem_sh - {1'b0, divisor});
        q_nxt   = {q_r[ACC_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[CW-1:0];
        q_nxt   = {q_r[ACC_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == ($clog2(ACC_W))'(ACC_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? acc_t'(-q_r) : acc_t'(q_r);

endmodule

@@ hdl/linear_regression_gd_trainer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_regression_gd_trainer_top
// Linear regression trainer by batch gradient descent, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage: an input word is taken when start is high and busy is low. With
// in_func low it loads one sample (features and label) into the sample RAM
// while it is not full; a load without in_last_sample leaves busy low, so
// loads can follow every cycle. A load with in_last_sample runs the training
// and then emits bias and weights as NF+1 result words on consecutive
// cycles, out_last_result on the last. With in_func high the block returns
// one prediction word. Each training pass reads every stored sample from the
// sample RAM and does four shared multiplies for its prediction and four for
// its gradient, then divides each gradient sum by the sample count in the
// bit-serial divider and updates each weight; the pass runs iteration_count
// times. Each result word is on the out_ ports for one cycle, marked by
// out_strobe; the receiver cannot stall. Reset clears weights, sample count
// and the registers to their defaults; the sample RAM holds no reset value.
// Configuration is written through cfg_we; the user must do so only while
// busy is low, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module linear_regression_gd_trainer_top #(
  parameter int MAX_SAMPLES = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_func,
  input  lrgd_pkg::data_t        in_feature_0,
  input  lrgd_pkg::data_t        in_feature_1,
  input  lrgd_pkg::data_t        in_feature_2,
  input  lrgd_pkg::data_t        in_feature_3,
  input  lrgd_pkg::data_t        in_label,
  input  logic                   in_last_sample,
  output logic                   out_strobe,
  output logic                   out_result_kind,
  output lrgd_pkg::data_t        out_value,
  output logic [2:0]             out_weight_index,
  output logic                   out_last_result,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [23:0]            cfg_wdata
);
  import lrgd_pkg::*;

  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_CAP  = 4'd2;
  localparam logic [3:0] S_PMUL = 4'd3;
  localparam logic [3:0] S_PACC = 4'd4;
  localparam logic [3:0] S_ERR  = 4'd5;
  localparam logic [3:0] S_GMUL = 4'd6;
  localparam logic [3:0] S_GACC = 4'd7;
  localparam logic [3:0] S_UPD  = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_SLO  = 4'd10;
  localparam logic [3:0] S_SHI  = 4'd11;
  localparam logic [3:0] S_WUPD = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;
  localparam logic [3:0] S_POUT = 4'd14;

  logic [3:0]          state_r, state_nxt;
  logic [IDX_W-1:0]    j_r, j_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [ITER_W-1:0]   iter_r, iter_nxt;
  logic [LR_W-1:0]     lr_r;
  logic [ITER_W-1:0]   itc_r;
  data_t               x_r [NF];
  data_t               x_nxt [NF];
  data_t               lbl_r, lbl_nxt;
  acc_t                acc_r, acc_nxt;
  acc_t                prod_r, prod_nxt;
  data_t               err_r, err_nxt;
  acc_t                sum_r [NF+1];
  acc_t                sum_nxt [NF+1];
  data_t               w_r [NF+1];
  data_t               w_nxt [NF+1];
  logic signed [MEAN_W-1:0] mean_r, mean_nxt;
  logic [LR_W+19:0]    plo_r, plo_nxt;
  logic signed [LR_W+20:0] phi_r, phi_nxt;
  logic                pred_r, pred_nxt;
  logic                ostb_r, ostb_nxt;
  logic                okind_r, okind_nxt;
  data_t               oval_r, oval_nxt;
  logic [IDX_W-1:0]    oidx_r, oidx_nxt;
  logic                olast_r, olast_nxt;

  logic                accept;
  logic                mem_we;
  row_t                row_in, row_rd;
  data_t               lbl_rd;
  logic                div_start, div_done;
  acc_t                div_q;
  logic [IDX_W-1:0]    wj;
  logic                j_last_f, j_last_w, idx_last;
  data_t               err_c;
  logic signed [ACC_W+1:0] step_full, step_sh;
  acc_t                wdiff;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);
  assign mem_we = accept && (in_func == FUNC_LOAD) && (cnt_r < CW'(MAX_SAMPLES));
  assign row_in = {in_feature_3, in_feature_2, in_feature_1, in_feature_0};

  // sample rows and labels
  lrgd_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SAMPLES)) u_feat_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (row_in),
    .raddr (idx_r),
    .rdata (row_rd)
  );

  lrgd_ram #(.WIDTH(DW), .DEPTH(MAX_SAMPLES)) u_label_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (in_label),
    .raddr (idx_r),
    .rdata (lbl_rd)
  );

  // mean of one gradient sum
  lrgd_div #(.CW(CW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r[j_r]),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign wj       = j_r + 1'b1;
  assign j_last_f = (j_r == IDX_W'(NF - 1));
  assign j_last_w = (j_r == IDX_W'(NF));
  assign idx_last = ({1'b0, idx_r} == (AW+1)'(cnt_r - 1'b1));
  assign err_c    = sat_dw(acc_r - acc_t'(lbl_r));

  // weight step from the two partial products
  always_comb begin
    step_full = ((ACC_W+2)'(phi_r) <<< 20) + (ACC_W+2)'(signed'({1'b0, plo_r}));
    step_sh   = step_full >>> LR_W;
    wdiff     = acc_t'(w_r[j_r]) - step_sh[ACC_W-1:0];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    iter_nxt  = iter_r;
    lbl_nxt   = lbl_r;
    acc_nxt   = acc_r;
    prod_nxt  = prod_r;
    err_nxt   = err_r;
    mean_nxt  = mean_r;
    plo_nxt   = plo_r;
    phi_nxt   = phi_r;
    pred_nxt  = pred_r;
    ostb_nxt  = 1'b0;
    okind_nxt = okind_r;
    oval_nxt  = oval_r;
    oidx_nxt  = oidx_r;
    olast_nxt = olast_r;
    div_start = 1'b0;
    for (int k = 0; k < NF; k++) begin
      x_nxt[k] = x_r[k];
    end
    for (int k = 0; k <= NF; k++) begin
      sum_nxt[k] = sum_r[k];
      w_nxt[k]   = w_r[k];
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_PREDICT) begin
            x_nxt[0] = in_feature_0;
            x_nxt[1] = in_feature_1;
            x_nxt[2] = in_feature_2;
            x_nxt[3] = in_feature_3;
            acc_nxt   = acc_t'(w_r[0]);
            j_nxt     = '0;
            pred_nxt  = 1'b1;
            state_nxt = S_PMUL;
          end else begin
            if (mem_we) begin
              cnt_nxt = cnt_r + 1'b1;
            end
            if (in_last_sample) begin
              pred_nxt = 1'b0;
              j_nxt    = '0;
              idx_nxt  = '0;
              iter_nxt = '0;
              for (int k = 0; k <= NF; k++) begin
                sum_nxt[k] = '0;
              end
              if (itc_r == '0 || cnt_nxt == '0) begin
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_RD;
              end
            end
          end
        end
      end
      S_RD: begin
        state_nxt = S_CAP;
      end
      S_CAP: begin
        for (int k = 0; k < NF; k++) begin
          x_nxt[k] = row_rd[k*DW +: DW];
        end
        lbl_nxt   = lbl_rd;
        acc_nxt   = acc_t'(w_r[0]);
        j_nxt     = '0;
        state_nxt = S_PMUL;
      end
      S_PMUL: begin
        prod_nxt  = acc_t'(w_r[wj]) * acc_t'(x_r[j_r[XI_W-1:0]]);
        state_nxt = S_PACC;
      end
      S_PACC: begin
        acc_nxt = acc_r + (prod_r >>> FRAC);
        if (j_last_f) begin
          j_nxt     = '0;
          state_nxt = pred_r ? S_POUT : S_ERR;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_PMUL;
        end
      end
      S_ERR: begin
        err_nxt    = err_c;
        sum_nxt[0] = sum_r[0] + acc_t'(err_c);
        state_nxt  = S_GMUL;
      end
      S_GMUL: begin
        prod_nxt  = acc_t'(err_r) * acc_t'(x_r[j_r[XI_W-1:0]]);
        state_nxt = S_GACC;
      end
      S_GACC: begin
        sum_nxt[wj] = sum_r[wj] + (prod_r >>> FRAC);
        if (j_last_f) begin
          j_nxt = '0;
          if (idx_last) begin
            state_nxt = S_UPD;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_RD;
          end
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_GMUL;
        end
      end
      S_UPD: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          mean_nxt  = sat_mean(div_q);
          state_nxt = S_SLO;
        end
      end
      S_SLO: begin
        plo_nxt   = (LR_W+20)'(lr_r) * (LR_W+20)'(mean_r[19:0]);
        state_nxt = S_SHI;
      end
      S_SHI: begin
        phi_nxt   = (LR_W+21)'(signed'({1'b0, lr_r})) *
                    (LR_W+21)'(signed'(mean_r[MEAN_W-1:20]));
        state_nxt = S_WUPD;
      end
      S_WUPD: begin
        w_nxt[j_r] = sat_dw(wdiff);
        if (j_last_w) begin
          j_nxt    = '0;
          iter_nxt = iter_r + 1'b1;
          if (iter_nxt == itc_r) begin
            state_nxt = S_OUT;
          end else begin
            idx_nxt = '0;
            for (int k = 0; k <= NF; k++) begin
              sum_nxt[k] = '0;
            end
            state_nxt = S_RD;
          end
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_UPD;
        end
      end
      S_OUT: begin
        ostb_nxt  = 1'b1;
        okind_nxt = KIND_WEIGHT;
        oval_nxt  = w_r[j_r];
        oidx_nxt  = j_r;
        olast_nxt = j_last_w;
        if (j_last_w) begin
          j_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_POUT: begin
        ostb_nxt  = 1'b1;
        okind_nxt = KIND_PRED;
        oval_nxt  = sat_dw(acc_r);
        oidx_nxt  = '0;
        olast_nxt = 1'b1;
        pred_nxt  = 1'b0;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state, weights and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      j_r     <= '0;
      idx_r   <= '0;
      cnt_r   <= '0;
      iter_r  <= '0;
      pred_r  <= 1'b0;
      ostb_r  <= 1'b0;
      lr_r    <= LR_W'(16777);
      itc_r   <= ITER_W'(10000);
      for (int k = 0; k <= NF; k++) begin
        w_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      iter_r  <= iter_nxt;
      pred_r  <= pred_nxt;
      ostb_r  <= ostb_nxt;
      for (int k = 0; k <= NF; k++) begin
        w_r[k] <= w_nxt[k];
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LEARNING_RATE:   lr_r  <= cfg_wdata;
          REG_ITERATION_COUNT: itc_r <= cfg_wdata[ITER_W-1:0];
          default:             lr_r  <= lr_r;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    for (int k = 0; k < NF; k++) begin
      x_r[k] <= x_nxt[k];
    end
    for (int k = 0; k <= NF; k++) begin
      sum_r[k] <= sum_nxt[k];
    end
    lbl_r   <= lbl_nxt;
    acc_r   <= acc_nxt;
    prod_r  <= prod_nxt;
    err_r   <= err_nxt;
    mean_r  <= mean_nxt;
    plo_r   <= plo_nxt;
    phi_r   <= phi_nxt;
    okind_r <= okind_nxt;
    oval_r  <= oval_nxt;
    oidx_r  <= oidx_nxt;
    olast_r <= olast_nxt;
  end

  assign out_strobe       = ostb_r;
  assign out_result_kind  = okind_r;
  assign out_value        = oval_r;
  assign out_weight_index = oidx_r;
  assign out_last_result  = olast_r;

endmodule
